// ===== design/per_frame_ring_allocator_assert.svh =====
// Assertion macros for the per-frame ring allocator.
// All macros sample on clk_i and are disabled while rst_ni is low.
`ifndef PER_FRAME_RING_ALLOCATOR_ASSERT_SVH
`define PER_FRAME_RING_ALLOCATOR_ASSERT_SVH

// Generic property check
`define PFRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Signal holds in the cycle after a condition
`define PFRA_ASSERT_HOLD(lbl, cond, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

// ===== design/pfra_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pfra_pkg;

  // Sizes
  localparam int unsigned OffsetBits    = 28;
  localparam int unsigned MaxFrames     = 8;
  localparam int unsigned SizeW         = 25;
  localparam int unsigned FrameW        = 3;
  localparam int unsigned ShiftW        = 5;
  localparam int unsigned AlignShiftMax = 16;
  localparam int unsigned RegionMax     = 2 ** 24;
  localparam int unsigned RegionReset   = 65536;
  localparam int unsigned CntW          = $clog2(OffsetBits + 1);
  localparam int unsigned InDataW       = 32;
  localparam int unsigned OutDataW      = 32;
  localparam int unsigned OutUserW      = 2;
  localparam int unsigned CfgIdxW       = 1;
  localparam int unsigned CfgDataW      = 25;

  // Item commands
  typedef enum logic {
    CmdAlloc = 1'b0,
    CmdReset = 1'b1
  } cmd_e;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgAlignShift = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgFrameSize  = CfgIdxW'(1);

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } dp_ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic is_reset;
  } dp_stat_t;

  // Round up to a multiple of 1 << sh
  function automatic logic [OffsetBits:0] round_up(input logic [OffsetBits-1:0] v,
                                                   input logic [ShiftW-1:0] sh);
    logic [OffsetBits:0] m;
    m = (OffsetBits + 1)'(1) << sh;
    m = m - (OffsetBits + 1)'(1);
    return ({1'b0, v} + m) & ~m;
  endfunction

endpackage

`default_nettype wire

// ===== design/pfra_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "per_frame_ring_allocator_assert.svh"

module pfra_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire pfra_pkg::dp_stat_t stat_i,
  output pfra_pkg::dp_ctrl_t     ctrl_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StDiv  = 3'b010,
    StDone = 3'b100
  } state_e;

  state_e                      state_q, state_d;
  logic [pfra_pkg::CntW-1:0]   count_q, count_d;
  logic                        out_valid_q, out_valid_d;
  logic                        accept;
  logic                        last_step;

  assign accept    = in_valid_i && (state_q == StIdle);
  assign last_step = count_q == pfra_pkg::CntW'(pfra_pkg::OffsetBits - 1);

  // Datapath commands
  always_comb begin
    ctrl_o.load   = accept;
    ctrl_o.step   = state_q == StDiv;
    ctrl_o.commit = (state_q == StDone) && (!out_valid_q || out_ready_i);
  end

  // Next state and step counter
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StDiv;
          count_d = '0;
        end
      end
      StDiv: begin
        count_d = count_q + pfra_pkg::CntW'(1);
        if (stat_i.is_reset || last_step) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (ctrl_o.commit) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output word valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == StIdle;
  assign out_valid_o = out_valid_q;

  `PFRA_ASSERT(a_accept_div, accept |=> (state_q == StDiv), "accepted word did not start division")
  `PFRA_ASSERT(a_div_bound, (state_q == StDiv) |-> (count_q < pfra_pkg::CntW'(pfra_pkg::OffsetBits)), "division step count overran")
  `PFRA_ASSERT(a_commit_free, ctrl_o.commit |-> (!out_valid_q || out_ready_i), "result overwrote a pending word")
  `PFRA_ASSERT(a_commit_valid, ctrl_o.commit |=> out_valid_q, "committed result not presented")
  `PFRA_ASSERT_HOLD(a_cnt_hold, state_q == StDone, count_q, "step count moved while waiting")

endmodule

`default_nettype wire

// ===== design/pfra_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfra_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [pfra_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [pfra_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                           in_cmd_i,
  input  wire logic [pfra_pkg::SizeW-1:0]     in_size_i,
  input  wire logic [pfra_pkg::FrameW-1:0]    in_frame_i,
  input  wire pfra_pkg::dp_ctrl_t             ctrl_i,
  output pfra_pkg::dp_stat_t                  stat_o,
  output logic [pfra_pkg::OffsetBits-1:0]     out_offset_o,
  output logic                                out_wrapped_o,
  output logic                                out_oversize_o
);

  localparam int unsigned OffW = pfra_pkg::OffsetBits;
  localparam int unsigned SzW  = pfra_pkg::SizeW;

  // Configuration registers
  logic [pfra_pkg::ShiftW-1:0]  align_shift_q;
  logic [SzW-1:0]               frame_size_q;

  // Running state and item registers
  logic [OffW-1:0]              run_off_q;
  pfra_pkg::cmd_e               item_cmd_q;
  logic [SzW:0]                 aligned_q;
  logic [pfra_pkg::FrameW-1:0]  item_frame_q;

  // Divider registers
  logic [SzW-1:0]               rem_q, rem_d;
  logic [OffW-1:0]              dvd_q;

  // Result registers
  logic [OffW-1:0]              res_off_q;
  logic                         res_wrap_q;
  logic                         res_over_q;

  logic [pfra_pkg::ShiftW-1:0]  shift_eff;
  logic [SzW-1:0]               region;
  logic [OffW:0]                in_rounded;
  logic [SzW:0]                 shifted;
  logic [pfra_pkg::FrameW-1:0]  frame_eff;
  logic [SzW+pfra_pkg::FrameW-1:0] prod;
  logic [OffW:0]                reset_rounded;
  logic [SzW+1:0]               fit_sum;
  logic                         wrap;
  logic                         over;
  logic [OffW-1:0]              base;
  logic [OffW-1:0]              cur;
  logic [OffW-1:0]              next_off;
  logic [OffW-1:0]              res_off_d;

  // Effective register values
  assign shift_eff = (align_shift_q > pfra_pkg::ShiftW'(pfra_pkg::AlignShiftMax)) ?
                     pfra_pkg::ShiftW'(pfra_pkg::AlignShiftMax) : align_shift_q;
  always_comb begin
    if (frame_size_q == '0) begin
      region = SzW'(1);
    end else if (frame_size_q > SzW'(pfra_pkg::RegionMax)) begin
      region = SzW'(pfra_pkg::RegionMax);
    end else begin
      region = frame_size_q;
    end
  end

  // Aligned request size, taken at load
  assign in_rounded = pfra_pkg::round_up(OffW'(in_size_i), shift_eff);

  // One restoring step of offset mod region
  assign shifted = {rem_q, dvd_q[OffW-1]};
  assign rem_d   = (shifted >= {1'b0, region}) ? SzW'(shifted - {1'b0, region}) :
                   SzW'(shifted);

  // Frame restart offset
  assign frame_eff = (32'(item_frame_q) >= pfra_pkg::MaxFrames) ?
                     pfra_pkg::FrameW'(pfra_pkg::MaxFrames - 1) : item_frame_q;
  assign prod          = {{pfra_pkg::FrameW{1'b0}}, region} * {{SzW{1'b0}}, frame_eff};
  assign reset_rounded = pfra_pkg::round_up(OffW'(prod), shift_eff);

  // Allocation: wrap test on the remainder, exact width
  assign fit_sum  = {2'b00, rem_q} + {1'b0, aligned_q};
  assign wrap     = fit_sum > (SzW + 2)'(region);
  assign over     = aligned_q > {1'b0, region};
  assign base     = run_off_q - OffW'(rem_q);
  assign cur      = wrap ? base : run_off_q;
  assign next_off = cur + OffW'(aligned_q);

  assign res_off_d = (item_cmd_q == pfra_pkg::CmdReset) ? reset_rounded[OffW-1:0] : cur;

  // Control state: configuration, item command and running offset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      align_shift_q <= '0;
      frame_size_q  <= SzW'(pfra_pkg::RegionReset);
      run_off_q     <= '0;
      item_cmd_q    <= pfra_pkg::CmdAlloc;
    end else begin
      if (cfg_we_i && (cfg_idx_i == pfra_pkg::CfgAlignShift)) begin
        align_shift_q <= cfg_data_i[pfra_pkg::ShiftW-1:0];
      end
      if (cfg_we_i && (cfg_idx_i == pfra_pkg::CfgFrameSize)) begin
        frame_size_q <= cfg_data_i[SzW-1:0];
      end
      if (ctrl_i.load) begin
        item_cmd_q <= pfra_pkg::cmd_e'(in_cmd_i);
      end
      if (ctrl_i.commit) begin
        run_off_q <= (item_cmd_q == pfra_pkg::CmdReset) ? reset_rounded[OffW-1:0] : next_off;
      end
    end
  end

  // Payload: item, divider and result
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      aligned_q    <= in_rounded[SzW:0];
      item_frame_q <= in_frame_i;
      rem_q        <= '0;
      dvd_q        <= run_off_q;
    end else if (ctrl_i.step) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[OffW-2:0], 1'b0};
    end
    if (ctrl_i.commit) begin
      res_off_q  <= res_off_d;
      res_wrap_q <= (item_cmd_q == pfra_pkg::CmdAlloc) && wrap;
      res_over_q <= (item_cmd_q == pfra_pkg::CmdAlloc) && over;
    end
  end

  assign stat_o.is_reset = item_cmd_q == pfra_pkg::CmdReset;
  assign out_offset_o    = res_off_q;
  assign out_wrapped_o   = res_wrap_q;
  assign out_oversize_o  = res_over_q;

endmodule

`default_nettype wire

// ===== design/per_frame_ring_allocator.sv =====
// Allocate word: 28 bit-serial steps of offset mod region, then the result is
// committed once the output register is free. Frame reset word: leaves the division
// after its first step. One word in flight; a new word is taken while the previous
// result still waits at the output register.
// Reset (rst_ni, asynchronous, active low): running offset 0, align_shift 0,
// per_frame_size 65536, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module per_frame_ring_allocator (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Configuration write
  input  wire logic                            cfg_we_i,
  input  wire logic [pfra_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [pfra_pkg::CfgDataW-1:0]   cfg_data_i,
  // Input words
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [pfra_pkg::InDataW-1:0]    s_axis_tdata,  // data_size, frame_index
  input  wire logic                            s_axis_tuser,  // command
  // Result words
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [pfra_pkg::OutDataW-1:0]        m_axis_tdata,  // offset
  output logic [pfra_pkg::OutUserW-1:0]        m_axis_tuser   // wrapped, oversize
);

  pfra_pkg::dp_ctrl_t                ctrl;
  pfra_pkg::dp_stat_t                stat;
  logic [pfra_pkg::OffsetBits-1:0]   offset;
  logic                              wrapped;
  logic                              oversize;

  pfra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  pfra_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_cmd_i       (s_axis_tuser),
    .in_size_i      (s_axis_tdata[pfra_pkg::SizeW-1:0]),
    .in_frame_i     (s_axis_tdata[pfra_pkg::SizeW +: pfra_pkg::FrameW]),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .out_offset_o   (offset),
    .out_wrapped_o  (wrapped),
    .out_oversize_o (oversize)
  );

  assign m_axis_tdata = {{(pfra_pkg::OutDataW - pfra_pkg::OffsetBits){1'b0}}, offset};
  assign m_axis_tuser = {oversize, wrapped};

endmodule

`default_nettype wire
